// ===== hdl/mbp_pkg.sv =====
`default_nettype none

package mbp_pkg;

  // input word layout
  localparam int InTdataW  = 40;
  localparam int ValueW    = 31;
  localparam int FwidthW   = 5;
  localparam int ResW      = 7;
  localparam int ResCntW   = 3;
  localparam int TotalW    = 6;
  localparam int AccW      = ValueW + ResW;
  localparam int AlignW    = 40;

  // queue between front and back
  localparam int QDepth    = 4;
  localparam int QPtrW     = 2;
  localparam int QCntW     = 3;

  typedef enum logic [0:0] {
    CMD_APPEND = 1'b0,
    CMD_FLUSH  = 1'b1
  } mbp_cmd_t;

  // up to four bytes, oldest byte in the top lane
  typedef struct packed {
    logic [3:0][7:0] bytes;
    logic [2:0]      cnt;
  } mbp_entry_t;

  // queue status seen by front and back
  typedef struct packed {
    logic full;
    logic empty;
  } mbp_qstat_t;

endpackage

`default_nettype wire

// ===== hdl/mbp_front.sv =====
`default_nettype none

module mbp_front
  import mbp_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                take,
  input  wire logic [0:0]          cmd,
  input  wire logic [ValueW-1:0]   fvalue,
  input  wire logic [FwidthW-1:0]  fwidth,
  output logic                     push,
  output mbp_entry_t               entry
);

  logic [ResW-1:0]    res_r,     res_nxt;
  logic [ResCntW-1:0] rcnt_r,    rcnt_nxt;
  logic [ValueW-1:0]  masked;
  logic [AccW-1:0]    acc;
  logic [TotalW-1:0]  total;
  logic [AlignW-1:0]  aligned;
  logic [TotalW-1:0]  lshift;

  // concatenate residue and new field, then left-align the whole run
  always_comb begin
    masked  = fvalue & ~({ValueW{1'b1}} << fwidth);
    acc     = ({{ValueW{1'b0}}, res_r} << fwidth) | {{ResW{1'b0}}, masked};
    total   = TotalW'(rcnt_r) + TotalW'(fwidth);
    lshift  = TotalW'(AlignW) - total;
    aligned = {{(AlignW-AccW){1'b0}}, acc} << lshift;
  end

  // classify the word: bytes to emit and the residue left behind
  always_comb begin
    entry    = '0;
    res_nxt  = res_r;
    rcnt_nxt = rcnt_r;
    case (mbp_cmd_t'(cmd))
      CMD_FLUSH: begin
        entry.bytes[3] = {1'b0, res_r};
        entry.cnt      = (rcnt_r != '0) ? 3'd1 : 3'd0;
        res_nxt        = '0;
        rcnt_nxt       = '0;
      end
      default: begin
        entry.bytes = aligned[AlignW-1 -: 32];
        entry.cnt   = total[TotalW-1:3];
        res_nxt     = acc[ResW-1:0] & ~({ResW{1'b1}} << total[2:0]);
        rcnt_nxt    = total[2:0];
      end
    endcase
  end

  assign push = take && (entry.cnt != '0);

  // residue state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_r  <= '0;
      rcnt_r <= '0;
    end else if (take) begin
      res_r  <= res_nxt;
      rcnt_r <= rcnt_nxt;
    end
  end

  // bits above the pending count stay clear
  a_res_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (res_r & ({ResW{1'b1}} << rcnt_r)) == '0)
    else $error("residue holds bits above its count");

endmodule

`default_nettype wire

// ===== hdl/mbp_fifo.sv =====
`default_nettype none

module mbp_fifo
  import mbp_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       wr,
  input  wire mbp_entry_t wdata,
  input  wire logic       rd,
  output mbp_entry_t      rdata,
  output mbp_qstat_t      stat
);

  mbp_entry_t        mem_r [QDepth];
  logic [QPtrW-1:0]  wp_r, wp_nxt;
  logic [QPtrW-1:0]  rp_r, rp_nxt;
  logic [QCntW-1:0]  cnt_r, cnt_nxt;

  assign stat.full  = (cnt_r == QCntW'(QDepth));
  assign stat.empty = (cnt_r == '0);
  assign rdata      = mem_r[rp_r];

  // pointer and fill count update
  always_comb begin
    wp_nxt  = wr ? wp_r + 1'b1 : wp_r;
    rp_nxt  = rd ? rp_r + 1'b1 : rp_r;
    cnt_nxt = cnt_r + QCntW'(wr) - QCntW'(rd);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (wr) begin
      mem_r[wp_r] <= wdata;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    stat.full |-> !wr)
    else $error("push into full queue");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    stat.empty |-> !rd)
    else $error("pop from empty queue");

endmodule

`default_nettype wire

// ===== hdl/mbp_back.sv =====
`default_nettype none

module mbp_back
  import mbp_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire mbp_entry_t  head,
  input  wire mbp_qstat_t  qstat,
  output logic             pop,
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [7:0]       out_tdata,
  output logic             out_tlast
);

  logic       vld_r;
  logic [7:0] byte_r;
  logic       last_r;
  logic [1:0] idx_r, idx_nxt;
  logic       slot_free;
  logic       emit;
  logic       lastb;

  // one byte per cycle from queue head to output register, unless stalled
  always_comb begin
    slot_free = !vld_r || out_tready;
    emit      = !qstat.empty && slot_free;
    lastb     = ({1'b0, idx_r} == (head.cnt - 3'd1));
    pop       = emit && lastb;
    idx_nxt   = idx_r;
    if (emit) begin
      idx_nxt = lastb ? 2'd0 : idx_r + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
      idx_r <= '0;
    end else begin
      idx_r <= idx_nxt;
      if (slot_free) begin
        vld_r <= emit;
      end
    end
  end

  // output word payload
  always_ff @(posedge clk) begin
    if (emit) begin
      byte_r <= head.bytes[~idx_r];
      last_r <= lastb;
    end
  end

  assign out_tvalid = vld_r;
  assign out_tdata  = byte_r;
  assign out_tlast  = last_r;

  // queued entries always carry at least one byte and the index stays inside
  a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
    !qstat.empty |-> (head.cnt != '0) && ({1'b0, idx_r} < head.cnt))
    else $error("byte index outside entry");

endmodule

`default_nettype wire

// ===== hdl/msb_first_bit_packer_top.sv =====
// first byte of a word: written into the queue entry, then registered in the
//   output register and valid on out_tdata until taken
// throughput: one input word per cycle while the queue has room; a word that
//   yields k bytes leaves the output one byte per cycle while out_tready is high
// a four-entry queue separates the packing front from the byte emitter
// reset (rst_n low, synchronous): residue cleared, queue emptied, out_tvalid low
`default_nettype none

module msb_first_bit_packer_top
  import mbp_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_tvalid,
  output logic                     in_tready,
  input  wire logic [InTdataW-1:0] in_tdata,  // field_value[30:0], field_width[35:31], 0
  input  wire logic [0:0]          in_tuser,  // command[0]
  output logic                     out_tvalid,
  input  wire logic                out_tready,
  output logic [7:0]               out_tdata, // out_byte[7:0]
  output logic                     out_tlast
);

  logic       take;
  logic       push;
  logic       pop;
  mbp_entry_t push_entry;
  mbp_entry_t head;
  mbp_qstat_t qstat;

  assign in_tready = !qstat.full;
  assign take      = in_tvalid && in_tready;

  mbp_front u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .take   (take),
    .cmd    (in_tuser),
    .fvalue (in_tdata[ValueW-1:0]),
    .fwidth (in_tdata[ValueW +: FwidthW]),
    .push   (push),
    .entry  (push_entry)
  );

  mbp_fifo u_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .wr    (push),
    .wdata (push_entry),
    .rd    (pop),
    .rdata (head),
    .stat  (qstat)
  );

  mbp_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head       (head),
    .qstat      (qstat),
    .pop        (pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule

`default_nettype wire
